@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, clocked on clk. Empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked outside reset
`define RBM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked in every cycle, reset included
`define RBM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RBM_ASSERT(label, prop, msg)
`define RBM_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ src/rbm_pkg.sv @@
// ----------------------------------------------------------------------------
// rbm_pkg
// Shared types and constants for the record bitmap and missing-run reporter.
// ----------------------------------------------------------------------------
package rbm_pkg;

  localparam int MAX_RECORDS = 65536;
  localparam int MAX_RUNS    = 32;

  localparam int REC_W   = 16;
  localparam int WORD_W  = 64;
  localparam int WORD_SH = $clog2(WORD_W);
  localparam int POS_W   = WORD_SH + 1;
  localparam int WORDS   = MAX_RECORDS / WORD_W;
  localparam int ADDR_W  = $clog2(WORDS);
  localparam int CNT_W   = $clog2(MAX_RUNS + 1);
  localparam int RUN_IW  = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;

  localparam logic [WORD_W-1:0] WORD_ONES = {WORD_W{1'b1}};

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_MARK   = 2'd1;
  localparam logic [1:0] CMD_REPORT = 2'd2;

  typedef struct packed {
    logic [1:0]       command;
    logic [REC_W-1:0] range_first;
    logic [REC_W-1:0] range_last;
  } rbm_item_t;

  typedef struct packed {
    logic [REC_W-1:0] run_first;
    logic [REC_W-1:0] run_last;
    logic             none_missing;
    logic             last_of_run;
    logic             truncated;
    logic             transfer_complete;
  } rbm_result_t;

  typedef struct packed {
    logic [REC_W-1:0] first;
    logic [REC_W-1:0] last;
  } rbm_run_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } rbm_ram_req_t;

  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic               in_run;
    logic [POS_W-1:0]   pos;
    logic [WORD_SH-1:0] hb;
  } rbm_find_req_t;

  typedef struct packed {
    logic               found;
    logic [WORD_SH-1:0] idx;
  } rbm_find_rsp_t;

endpackage

@@ src/record_bitmap_missing_ranges.sv @@
// ----------------------------------------------------------------------------
// record_bitmap_missing_ranges
// Received-record bitmap with clear, range mark and missing-run reporting.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                      payload
//  item      in         item_valid / item_stall        item   (rbm_item_t)
//  result    out        result_valid / result_stall    result (rbm_result_t)
//  config    in         cfg_wr_en                      cfg_wr_data (rec_total)
//
// The bitmap is a 1024 x 64-bit RAM, one read and one write per cycle.
// Clear zeroes each word in turn; mark reads each spanned word and writes it
// back ORed with the mark mask. Report reads and scans each word, then sends
// its results; the edge finder handles one boundary per cycle.
// After reset a clearing pass over all 1024 words runs with item_stall high.
// A finished result waits in the output register while the next item starts.
// ----------------------------------------------------------------------------
module record_bitmap_missing_ranges (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  rbm_pkg::rbm_item_t          item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output rbm_pkg::rbm_result_t        result,
  input  logic                        cfg_wr_en,
  input  logic [rbm_pkg::REC_W-1:0]   cfg_wr_data
);
  import rbm_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_MARK  = 6'b000100,
    S_RD    = 6'b001000,
    S_SCAN  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t            state;
  logic [REC_W-1:0]  rec_total;
  logic [ADDR_W-1:0] word_addr;
  logic [ADDR_W-1:0] prev_addr;
  logic              pend;
  logic              mk_more;
  logic [REC_W-1:0]  range_lo;
  logic [REC_W-1:0]  range_hi;
  logic [POS_W-1:0]  pos;
  logic              in_run;
  logic [REC_W-1:0]  run_start;
  logic [CNT_W-1:0]  run_count;
  logic [CNT_W-1:0]  emit_idx;
  logic              trunc;
  logic              report_done;
  rbm_run_t          run_mem [MAX_RUNS];

  rbm_ram_req_t      ram_req;
  logic [WORD_W-1:0] ram_rdata;
  rbm_find_req_t     find_req;
  rbm_find_rsp_t     find_rsp;

  logic              accept;
  logic [REC_W-1:0]  tot_eff;
  logic [REC_W-1:0]  mark_lo;
  logic [REC_W-1:0]  clamp_last;
  logic [ADDR_W-1:0] lo_word;
  logic [ADDR_W-1:0] hi_word;
  logic [WORD_SH-1:0] mk_lb;
  logic [WORD_SH-1:0] mk_hb;
  logic [WORD_W-1:0] mark_mask;
  logic              at_hi_word;
  logic [REC_W-1:0]  edge_rec;
  logic              out_free;
  logic              emit_last;
  rbm_run_t          emit_run;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  always_comb begin
    tot_eff    = ({16'd0, rec_total} > 32'(MAX_RECORDS - 1)) ?
                 REC_W'(MAX_RECORDS - 1) : rec_total;
    mark_lo    = (item.range_first == '0) ? REC_W'(1) : item.range_first;
    clamp_last = (item.range_last > tot_eff) ? tot_eff : item.range_last;
    lo_word    = ADDR_W'(range_lo >> WORD_SH);
    hi_word    = ADDR_W'(range_hi >> WORD_SH);
    at_hi_word = (word_addr == hi_word);
  end

  // mark mask for the word whose read data is back this cycle
  always_comb begin
    mk_lb     = (prev_addr == lo_word) ? range_lo[WORD_SH-1:0] : '0;
    mk_hb     = (prev_addr == hi_word) ? range_hi[WORD_SH-1:0] : WORD_SH'(WORD_W - 1);
    mark_mask = (WORD_ONES << mk_lb) & (WORD_ONES >> (WORD_SH'(WORD_W - 1) - mk_hb));
  end

  always_comb begin
    ram_req = '0;
    case (state)
      S_CLEAR: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = word_addr;
        ram_req.wr_data = '0;
      end
      S_MARK: begin
        ram_req.wr_en   = pend;
        ram_req.wr_addr = prev_addr;
        ram_req.wr_data = ram_rdata | mark_mask;
        ram_req.rd_en   = mk_more;
        ram_req.rd_addr = word_addr;
      end
      S_RD: begin
        ram_req.rd_en   = 1'b1;
        ram_req.rd_addr = word_addr;
      end
      default: begin
        ram_req = '0;
      end
    endcase
  end

  always_comb begin
    find_req.word   = ram_rdata;
    find_req.in_run = in_run;
    find_req.pos    = pos;
    find_req.hb     = at_hi_word ? range_hi[WORD_SH-1:0] : WORD_SH'(WORD_W - 1);
    edge_rec        = REC_W'({word_addr, find_rsp.idx});
    emit_run        = run_mem[emit_idx[RUN_IW-1:0]];
    emit_last       = ((emit_idx + CNT_W'(1)) == run_count);
  end

  rbm_map_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rdata)
  );

  rbm_find_edge u_find (
    .req (find_req),
    .rsp (find_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_total <= '0;
    end else if (cfg_wr_en) begin
      rec_total <= cfg_wr_data;
    end
  end

  // run buffer: hold up to MAX_RUNS runs until the report knows its flags
  always_ff @(posedge clk) begin
    if (state == S_SCAN && run_count < CNT_W'(MAX_RUNS)) begin
      if (find_rsp.found && in_run) begin
        run_mem[run_count[RUN_IW-1:0]] <= '{first: run_start, last: edge_rec - REC_W'(1)};
      end else if (!find_rsp.found && at_hi_word && in_run) begin
        run_mem[run_count[RUN_IW-1:0]] <= '{first: run_start, last: range_hi};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      word_addr    <= '0;
      prev_addr    <= '0;
      pend         <= 1'b0;
      mk_more      <= 1'b0;
      pos          <= '0;
      in_run       <= 1'b0;
      run_start    <= '0;
      run_count    <= '0;
      emit_idx     <= '0;
      trunc        <= 1'b0;
      report_done  <= 1'b0;
      range_lo     <= '0;
      range_hi     <= '0;
      result_valid <= 1'b0;
      result       <= '0;
    end else begin
      if (state == S_EMIT && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          word_addr <= word_addr + ADDR_W'(1);
          if (word_addr == ADDR_W'(WORDS - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (accept) begin
            case (item.command)
              CMD_CLEAR: begin
                word_addr <= '0;
                state     <= S_CLEAR;
              end
              CMD_MARK: begin
                range_lo  <= mark_lo;
                range_hi  <= clamp_last;
                word_addr <= ADDR_W'(mark_lo >> WORD_SH);
                pend      <= 1'b0;
                mk_more   <= 1'b1;
                if (mark_lo <= clamp_last) begin
                  state <= S_MARK;
                end
              end
              CMD_REPORT: begin
                range_lo    <= item.range_first;
                range_hi    <= clamp_last;
                word_addr   <= ADDR_W'(item.range_first >> WORD_SH);
                pos         <= POS_W'(item.range_first[WORD_SH-1:0]);
                in_run      <= 1'b0;
                run_count   <= '0;
                emit_idx    <= '0;
                trunc       <= 1'b0;
                report_done <= (item.range_last >= rec_total);
                // empty range goes straight to the nothing-missing result
                state       <= (item.range_first > clamp_last) ? S_EMIT : S_RD;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end

        S_MARK: begin
          prev_addr <= word_addr;
          pend      <= mk_more;
          if (mk_more) begin
            if (at_hi_word) begin
              mk_more <= 1'b0;
            end else begin
              word_addr <= word_addr + ADDR_W'(1);
            end
          end else begin
            state <= S_IDLE;
          end
        end

        S_RD: begin
          state <= S_SCAN;
        end

        S_SCAN: begin
          if (find_rsp.found) begin
            pos    <= POS_W'(find_rsp.idx) + POS_W'(1);
            in_run <= !in_run;
            if (!in_run) begin
              run_start <= edge_rec;
            end else if (run_count < CNT_W'(MAX_RUNS)) begin
              run_count <= run_count + CNT_W'(1);
            end else begin
              trunc <= 1'b1;
            end
          end else if (at_hi_word) begin
            // close a run still open at the end of the range
            if (in_run) begin
              if (run_count < CNT_W'(MAX_RUNS)) begin
                run_count <= run_count + CNT_W'(1);
              end else begin
                trunc <= 1'b1;
              end
            end
            in_run <= 1'b0;
            state  <= S_EMIT;
          end else begin
            word_addr <= word_addr + ADDR_W'(1);
            pos       <= '0;
            state     <= S_RD;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            if (run_count == '0) begin
              result.run_first         <= '0;
              result.run_last          <= '0;
              result.none_missing      <= 1'b1;
              result.last_of_run       <= 1'b1;
              result.truncated         <= 1'b0;
              result.transfer_complete <= report_done;
              state                    <= S_IDLE;
            end else begin
              result.run_first         <= emit_run.first;
              result.run_last          <= emit_run.last;
              result.none_missing      <= 1'b0;
              result.last_of_run       <= emit_last;
              result.truncated         <= trunc;
              result.transfer_complete <= 1'b0;
              emit_idx                 <= emit_idx + CNT_W'(1);
              if (emit_last) begin
                state <= S_IDLE;
              end
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "assert_macros.svh"

  `RBM_ASSERT(a_run_count_max, run_count <= CNT_W'(MAX_RUNS), "run count above limit")
  `RBM_ASSERT(a_none_is_final,
              result_valid && result.none_missing |-> result.last_of_run && !result.truncated,
              "nothing-missing result not final")
  `RBM_ASSERT(a_run_ordered,
              result_valid && !result.none_missing |-> result.run_first <= result.run_last,
              "run ends before it starts")
  `RBM_ASSERT(a_scan_no_write,
              (state == S_RD || state == S_SCAN) |-> !ram_req.wr_en,
              "bitmap written during scan")
  `RBM_ASSERT_ALWAYS(a_reset_clears, rst |=> state == S_CLEAR, "no clearing pass after reset")

endmodule

@@ src/rbm_map_ram.sv @@
// ----------------------------------------------------------------------------
// rbm_map_ram
// Bitmap storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rbm_map_ram (
  input  logic                          clk,
  input  rbm_pkg::rbm_ram_req_t         req,
  output logic [rbm_pkg::WORD_W-1:0]    rd_data
);
  import rbm_pkg::*;

  logic [WORD_W-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

@@ src/rbm_find_edge.sv @@
// ----------------------------------------------------------------------------
// rbm_find_edge
// Finds the lowest bit at or above pos, up to hb, where the map word leaves
// the current run state (next 0 outside a run, next 1 inside one).
// ----------------------------------------------------------------------------
module rbm_find_edge (
  input  rbm_pkg::rbm_find_req_t req,
  output rbm_pkg::rbm_find_rsp_t rsp
);
  import rbm_pkg::*;

  logic [WORD_W-1:0] target;
  logic [WORD_W-1:0] lo_mask;
  logic [WORD_W-1:0] hi_mask;
  logic [WORD_W-1:0] hits;

  always_comb begin
    target  = req.in_run ? req.word : ~req.word;
    lo_mask = req.pos[POS_W-1] ? '0 : (WORD_ONES << req.pos[WORD_SH-1:0]);
    hi_mask = WORD_ONES >> (WORD_SH'(WORD_W - 1) - req.hb);
    hits    = target & lo_mask & hi_mask;
  end

  always_comb begin
    rsp.found = |hits;
    rsp.idx   = '0;
    // scan downward so the lowest hit wins
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (hits[i]) begin
        rsp.idx = WORD_SH'(i);
      end
    end
  end

endmodule
